// ----- hdl/json_comment_stripper_unit_defines.svh -----
// Assertion macros for the comment stripper checker.
`ifndef JSON_COMMENT_STRIPPER_UNIT_DEFINES_SVH
`define JSON_COMMENT_STRIPPER_UNIT_DEFINES_SVH

// Clocked assertion, muted while reset is held.
`define JCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define JCS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/jcs_pkg.sv -----
// Shared types and constants for the JSON comment stripper.
`timescale 1ns / 1ps

package jcs_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 19;
    localparam int DEPTH_W = 8;

    localparam logic [POS_W-1:0]   POS_MAX          = {POS_W{1'b1}};
    localparam logic [DEPTH_W-1:0] DEF_MAX_NESTING  = 8'd32;
    localparam int                 DEF_MAX_TEXT_LEN = 262144;
    localparam int                 DEF_QUEUE_DEPTH  = 4;

    // Status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_DEEP   = 2'd1;
    localparam logic [1:0] STATUS_UNTERM = 2'd2;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    // One classified byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;      // first byte of a text
        logic              last;       // final byte, no lookahead
        logic              nxt_slash;  // following byte is a slash
        logic              nxt_star;   // following byte is a star
    } t_entry;

endpackage

// ----- hdl/jcs_front.sv -----
// Front end: holds one byte for lookahead and pushes classified words.
`timescale 1ns / 1ps

module jcs_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [jcs_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                      i_in_last,
    input  logic                      i_q_ready,
    output logic                      o_push,
    output jcs_pkg::t_entry           o_entry
);
    import jcs_pkg::*;

    logic              r_held_valid;
    logic              r_held_last;
    logic              r_held_first;
    logic [BYTE_W-1:0] r_held_byte;
    logic              w_accept;

    // Take a word whenever the held slot is empty or can drain into the queue
    assign o_in_ready = !r_held_valid || i_q_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Push the held byte once its follower is known, or at once if final
    assign o_push = r_held_valid && i_q_ready && (r_held_last || i_in_valid);

    always_comb begin
        o_entry.data      = r_held_byte;
        o_entry.first     = r_held_first;
        o_entry.last      = r_held_last;
        o_entry.nxt_slash = !r_held_last && (i_in_byte == CH_SLASH);
        o_entry.nxt_star  = !r_held_last && (i_in_byte == CH_STAR);
    end

    // Hold control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_last  <= 1'b0;
            r_held_first <= 1'b0;
        end else if (w_accept) begin
            r_held_valid <= 1'b1;
            r_held_last  <= i_in_last;
            r_held_first <= !r_held_valid || r_held_last;
        end else if (o_push) begin
            r_held_valid <= 1'b0;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_held_byte <= i_in_byte;
        end
    end

endmodule

// ----- hdl/jcs_queue.sv -----
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module jcs_queue #(
    parameter int DEPTH = jcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jcs_pkg::t_entry i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output jcs_pkg::t_entry o_entry
);
    import jcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry            r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- hdl/jcs_back.sv -----
// Back end: comment, string and nesting tracking plus the output register.
`timescale 1ns / 1ps

module jcs_back #(
    parameter int MAX_TEXT_LEN = jcs_pkg::DEF_MAX_TEXT_LEN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  jcs_pkg::t_entry             i_entry,
    input  logic [jcs_pkg::DEPTH_W-1:0] i_max_nesting,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [jcs_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_out_last,
    output logic [1:0]                  o_status,
    output logic [jcs_pkg::POS_W-1:0]   o_error_position
);
    import jcs_pkg::*;

    localparam logic [POS_W-1:0] INDEX_LIMIT =
        (MAX_TEXT_LEN < int'(POS_MAX)) ? POS_W'(MAX_TEXT_LEN) : POS_MAX;

    logic               r_block;
    logic               r_line;
    logic               r_quote;
    logic               r_esc;
    logic               r_consumed;
    logic [DEPTH_W-1:0] r_depth;
    logic [POS_W-1:0]   r_index;
    logic [1:0]         r_err;
    logic [POS_W-1:0]   r_err_pos;

    logic               n_block;
    logic               n_line;
    logic               n_quote;
    logic               n_esc;
    logic               n_consumed;
    logic [DEPTH_W-1:0] n_depth;
    logic [POS_W-1:0]   n_index;
    logic [1:0]         n_err;
    logic [POS_W-1:0]   n_err_pos;
    logic [BYTE_W-1:0]  n_byte;

    logic [BYTE_W-1:0]  w_c;
    logic               w_is_nl;
    logic               w_too_deep;

    // Advance whenever the output register is free or being taken
    assign o_pop = i_valid && (!o_out_valid || i_out_ready);

    assign w_c        = i_entry.data;
    assign w_is_nl    = (w_c == CH_LF) || (w_c == CH_CR);
    assign w_too_deep = ({1'b0, r_depth} + 9'd1) > {1'b0, i_max_nesting};

    // Handle one byte
    always_comb begin
        n_block    = r_block;
        n_line     = r_line;
        n_quote    = r_quote;
        n_esc      = r_esc;
        n_consumed = r_consumed;
        n_depth    = r_depth;
        n_err      = i_entry.first ? STATUS_OK : r_err;
        n_err_pos  = i_entry.first ? '0 : r_err_pos;
        n_index    = (r_index < INDEX_LIMIT) ? r_index + 1'b1 : r_index;
        n_byte     = w_c;

        if (n_err != STATUS_OK) begin
            n_consumed = 1'b0;
        end else if (r_consumed) begin
            n_consumed = 1'b0;
            n_byte     = CH_SPACE;
        end else if (r_block) begin
            if (w_c == CH_STAR && i_entry.nxt_slash) begin
                n_consumed = 1'b1;
                n_block    = 1'b0;
                n_byte     = CH_SPACE;
            end else if (!w_is_nl) begin
                n_byte = CH_SPACE;
            end
        end else if (r_line) begin
            if (w_is_nl) begin
                n_line = 1'b0;
            end else begin
                n_byte = CH_SPACE;
            end
        end else if (r_quote) begin
            if (r_esc) begin
                n_esc = 1'b0;
            end else if (w_c == CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (w_c == CH_QUOTE) begin
                n_quote = 1'b0;
            end
        end else if (w_c == CH_QUOTE) begin
            n_quote = 1'b1;
        end else if (w_c == CH_SLASH && (i_entry.nxt_slash || i_entry.nxt_star)) begin
            n_consumed = 1'b1;
            n_line     = i_entry.nxt_slash;
            n_block    = i_entry.nxt_star;
            n_byte     = CH_SPACE;
        end else if (w_c == CH_LBRACE || w_c == CH_LBRACK) begin
            if (w_too_deep) begin
                n_err     = STATUS_DEEP;
                n_err_pos = r_index;
            end else begin
                n_depth = r_depth + 1'b1;
            end
        end else if (w_c == CH_RBRACE || w_c == CH_RBRACK) begin
            if (r_depth != '0) begin
                n_depth = r_depth - 1'b1;
            end
        end

        // End of text: flag an open block comment, then drop text state
        if (i_entry.last) begin
            if (n_block && n_err == STATUS_OK) begin
                n_err     = STATUS_UNTERM;
                n_err_pos = n_index;
            end
            n_block    = 1'b0;
            n_line     = 1'b0;
            n_quote    = 1'b0;
            n_esc      = 1'b0;
            n_consumed = 1'b0;
            n_depth    = '0;
            n_index    = '0;
        end
    end

    // Parse state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block     <= 1'b0;
            r_line      <= 1'b0;
            r_quote     <= 1'b0;
            r_esc       <= 1'b0;
            r_consumed  <= 1'b0;
            r_depth     <= '0;
            r_index     <= '0;
            r_err       <= STATUS_OK;
            r_err_pos   <= '0;
            o_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_block     <= n_block;
            r_line      <= n_line;
            r_quote     <= n_quote;
            r_esc       <= n_esc;
            r_consumed  <= n_consumed;
            r_depth     <= n_depth;
            r_index     <= n_index;
            r_err       <= n_err;
            r_err_pos   <= n_err_pos;
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_out_byte       <= n_byte;
            o_out_last       <= i_entry.last;
            o_status         <= n_err;
            o_error_position <= n_err_pos;
        end
    end

endmodule

// ----- hdl/json_comment_stripper_unit.sv -----
// Top level of the JSON comment stripper.
`timescale 1ns / 1ps
//
// Input channel (i_in_valid / o_in_ready) takes one text byte per word with
// a last flag. Output channel (o_out_valid / i_out_ready) returns each byte,
// with comment bytes other than newlines turned into spaces until an error,
// plus the sticky status and the byte position of the recorded error.
// Config channel (i_cfg_valid / o_cfg_ready) writes max_nesting; write it
// only while the block is idle. Throughput: one word per cycle in and out
// while the receiver keeps up, set by the combinational parse step in the
// back end. A byte is pushed into the queue when its follower is accepted
// and then moves on to the output register; the final byte of a text is
// pushed without waiting for a follower. The front end holds one byte of
// lookahead; a four-word queue decouples it from the back end, so a stalled
// receiver first fills the output register, then the queue, then the held
// byte, and then drops o_in_ready.
// Reset (synchronous, active low) empties the queue and output register,
// clears all parse and error state and sets max_nesting to 32.

module json_comment_stripper_unit #(
    parameter int MAX_TEXT_LEN = jcs_pkg::DEF_MAX_TEXT_LEN,
    parameter int QUEUE_DEPTH  = jcs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [jcs_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_in_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [jcs_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_out_last,
    output logic [1:0]                  o_status,
    output logic [jcs_pkg::POS_W-1:0]   o_error_position,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [jcs_pkg::DEPTH_W-1:0] i_cfg_data
);
    import jcs_pkg::*;

    logic [DEPTH_W-1:0] r_max_nesting;
    logic               w_push;
    logic               w_q_ready;
    t_entry             w_push_entry;
    logic               w_q_valid;
    logic               w_pop;
    t_entry             w_head_entry;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_nesting <= DEF_MAX_NESTING;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_nesting <= i_cfg_data;
        end
    end

    jcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    jcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_head_entry)
    );

    jcs_back #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_valid),
        .o_pop            (w_pop),
        .i_entry          (w_head_entry),
        .i_max_nesting    (r_max_nesting),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_out_last       (o_out_last),
        .o_status         (o_status),
        .o_error_position (o_error_position)
    );

endmodule

// ----- hdl/jcs_checker.sv -----
// Port-level checks for the JSON comment stripper, bound to the top level.
`timescale 1ns / 1ps
`include "json_comment_stripper_unit_defines.svh"

module jcs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [jcs_pkg::BYTE_W-1:0]  o_out_byte,
    input logic                        o_out_last,
    input logic [1:0]                  o_status,
    input logic [jcs_pkg::POS_W-1:0]   o_error_position
);
    import jcs_pkg::*;

    logic                       w_stall;
    logic                       w_err_take;
    logic                       w_status_ok;
    logic [BYTE_W+POS_W+2:0]    w_out_word;
    logic [POS_W+1:0]           w_err_word;

    assign w_stall     = o_out_valid && !i_out_ready;
    assign w_err_take  = o_out_valid && i_out_ready && !o_out_last && o_status != STATUS_OK;
    assign w_status_ok = (o_status == STATUS_OK && o_error_position == '0) ||
                         o_status == STATUS_DEEP || o_status == STATUS_UNTERM;
    assign w_out_word  = {o_out_byte, o_out_last, o_status, o_error_position};
    assign w_err_word  = {o_status, o_error_position};

    // Nothing comes out right after reset
    `JCS_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A stalled output word holds
    `JCS_ASSERT(a_out_hold, w_stall |=> o_out_valid && $stable(w_out_word), "output changed")

    // No error means no error position, and no unused status code
    `JCS_ASSERT(a_ok_pos, o_out_valid |-> w_status_ok, "bad status or position")

    // An error stays put for the rest of the text
    `JCS_ASSERT(a_sticky, w_err_take |=> !o_out_valid || $stable(w_err_word), "error not sticky")

endmodule

bind json_comment_stripper_unit jcs_checker u_jcs_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the JSON comment stripper: directed, limit and random texts.
`timescale 1ns / 1ps

module tb_top;
    import jcs_pkg::*;

    localparam int TEXT_LEN       = DEF_MAX_TEXT_LEN;
    localparam int POS_LIMIT      = (TEXT_LEN < int'(POS_MAX)) ? TEXT_LEN : int'(POS_MAX);
    localparam int SETTLE_CYCLES  = 10;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 800;
    localparam int PHASE_BYTES    = 250;
    localparam int LONG_TEXT_LEN  = 200;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [1:0]        status;
        logic [POS_W-1:0]  pos;
    } t_strip_word;

    // Block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_in_byte = '0;
    logic                 i_in_last = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_out_last;
    logic [1:0]           o_status;
    logic [POS_W-1:0]     o_error_position;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [DEPTH_W-1:0]   i_cfg_data = '0;

    // Stripper model state
    logic [DEPTH_W-1:0]   max_nest_model;
    bit                   in_block, in_line, in_quote, esc_pending;
    logic [15:0]          depth_model;
    logic [BYTE_W-1:0]    held_data;
    bit                   held_valid, held_eaten;
    logic [POS_W-1:0]     next_pos;
    logic [1:0]           err_status;
    logic [POS_W-1:0]     err_pos;

    t_strip_word          pending_words[$];
    logic [BYTE_W-1:0]    text_q[$];

    // Run bookkeeping
    int n_errors = 0;
    int n_results = 0;
    int n_bytes = 0;
    int n_texts = 0;
    int n_cfg = 0;
    bit tx_up = 1'b0;
    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int rx_gap = 0;
    int idle_cycles = 0;

    json_comment_stripper_unit #(
        .MAX_TEXT_LEN (TEXT_LEN)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_in_last        (i_in_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_out_last       (o_out_last),
        .o_status         (o_status),
        .o_error_position (o_error_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_text_state();
        in_block    = 1'b0;
        in_line     = 1'b0;
        in_quote    = 1'b0;
        esc_pending = 1'b0;
        depth_model = '0;
        held_data   = '0;
        held_valid  = 1'b0;
        held_eaten  = 1'b0;
        next_pos    = '0;
    endfunction

    // Strip one byte; nxt is the byte after it when has_nxt is set.
    function automatic logic [BYTE_W-1:0] strip_byte(logic [BYTE_W-1:0] c, bit has_nxt,
                                                     logic [BYTE_W-1:0] nxt);
        logic [POS_W-1:0] idx;
        bit               nl;
        idx = next_pos;
        nl  = (c == CH_LF) || (c == CH_CR);
        if (int'(next_pos) < POS_LIMIT) next_pos = next_pos + 1'b1;

        if (err_status != STATUS_OK) begin
            held_eaten = 1'b0;
            return c;
        end
        if (held_eaten) begin
            held_eaten = 1'b0;
            return CH_SPACE;
        end
        if (in_block) begin
            if (c == CH_STAR && has_nxt && nxt == CH_SLASH) begin
                held_eaten = 1'b1;
                in_block   = 1'b0;
                return CH_SPACE;
            end
            return nl ? c : CH_SPACE;
        end
        if (in_line) begin
            if (!nl) return CH_SPACE;
            in_line = 1'b0;
            return c;
        end
        if (in_quote) begin
            if (esc_pending) esc_pending = 1'b0;
            else if (c == CH_BSLASH) esc_pending = 1'b1;
            else if (c == CH_QUOTE) in_quote = 1'b0;
            return c;
        end
        if (c == CH_QUOTE) begin
            in_quote = 1'b1;
            return c;
        end
        if (c == CH_SLASH && has_nxt && (nxt == CH_SLASH || nxt == CH_STAR)) begin
            held_eaten = 1'b1;
            if (nxt == CH_SLASH) in_line = 1'b1;
            else in_block = 1'b1;
            return CH_SPACE;
        end
        if (c == CH_LBRACE || c == CH_LBRACK) begin
            if (int'(depth_model) + 1 > int'(max_nest_model)) begin
                err_status = STATUS_DEEP;
                err_pos    = idx;
            end else begin
                depth_model = depth_model + 1'b1;
            end
        end else if (c == CH_RBRACE || c == CH_RBRACK) begin
            if (depth_model > 0) depth_model = depth_model - 1'b1;
        end
        return c;
    endfunction

    // Work out the words that one accepted input word releases.
    function automatic void predict_word(logic [BYTE_W-1:0] b, logic last);
        t_strip_word w;
        if (!held_valid) begin
            err_status = STATUS_OK;
            err_pos    = '0;
        end else begin
            w.data   = strip_byte(held_data, 1'b1, b);
            w.last   = 1'b0;
            w.status = err_status;
            w.pos    = err_pos;
            pending_words.push_back(w);
        end
        if (last) begin
            w.data = strip_byte(b, 1'b0, '0);
            if (in_block && err_status == STATUS_OK) begin
                err_status = STATUS_UNTERM;
                err_pos    = next_pos;
            end
            w.last   = 1'b1;
            w.status = err_status;
            w.pos    = err_pos;
            pending_words.push_back(w);
            clear_text_state();
        end else begin
            held_data  = b;
            held_valid = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------- checking

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (n_errors < MAX_PRINTS)
            $display("MISMATCH result %0d: %s got 0x%0h want 0x%0h", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic check_word();
        t_strip_word w;
        n_results++;
        if (pending_words.size() == 0) begin
            report_mismatch("unexpected word, byte", 32'(o_out_byte), 0);
            return;
        end
        w = pending_words.pop_front();
        if (o_out_byte !== w.data)
            report_mismatch("out_byte", 32'(o_out_byte), 32'(w.data));
        if (o_out_last !== w.last)
            report_mismatch("out_last", 32'(o_out_last), 32'(w.last));
        if (o_status !== w.status)
            report_mismatch("status", 32'(o_status), 32'(w.status));
        if (o_error_position !== w.pos)
            report_mismatch("error_position", 32'(o_error_position), 32'(w.pos));
    endtask

    // Sample every handshake at the edge: check first, then predict.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_word();
            if (i_in_valid && o_in_ready) begin
                predict_word(i_in_byte, i_in_last);
                n_bytes++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                max_nest_model = i_cfg_data;
                n_cfg++;
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d still pending",
                     idle_cycles, pending_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------- stimulus

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Drive output ready; a hold request drops it for a long stretch.
    always @(posedge i_clk) begin
        if (rx_hold_reqs != rx_hold_seen) begin
            rx_hold_seen++;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            rx_gap = rx_no_idle ? 0 : pick_gap();
        end
    end

    // Offer one word and hold it until accepted; valid stays up afterwards.
    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        int gap;
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            if (tx_up) begin
                i_in_valid <= 1'b0;
                tx_up = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        tx_up = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic tx_idle();
        if (tx_up) begin
            i_in_valid <= 1'b0;
            tx_up = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        tx_idle();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Drain and let the lookahead path settle before touching the register.
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_nesting(logic [DEPTH_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        n_texts++;
    endtask

    // Stop mid-text until every word so far has come back, then finish it.
    task automatic send_text_paused(int cut);
        for (int i = 0; i < text_q.size(); i++) begin
            if (i == cut) wait_results();
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        n_texts++;
    endtask

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s.getc(i));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_from(string s);
        return s.getc($urandom_range(0, s.len() - 1));
    endfunction

    function automatic logic [BYTE_W-1:0] any_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Random mostly well-formed text with strings, comments and brackets.
    function automatic void build_random_text();
        int n_tok, kind, len;
        text_q.delete();
        n_tok = $urandom_range(1, 12);
        for (int t = 0; t < n_tok; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                text_q.push_back(pick_from("{["));
            end else if (kind < 27) begin
                text_q.push_back(pick_from("}]"));
            end else if (kind < 42) begin
                text_q.push_back(CH_QUOTE);
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    case ($urandom_range(0, 9))
                        0: begin
                            text_q.push_back(CH_BSLASH);
                            text_q.push_back(pick_from("\"\\n/*u"));
                        end
                        1: text_q.push_back(pick_from("/*{[]}"));
                        2: text_q.push_back(any_byte());
                        default: text_q.push_back(pick_from("abcxyz 019:,"));
                    endcase
                end
                if ($urandom_range(0, 9) != 0) text_q.push_back(CH_QUOTE);
            end else if (kind < 52) begin
                add_str("//");
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) text_q.push_back(pick_from("ab */\"{[\\"));
                if ($urandom_range(0, 9) != 0) text_q.push_back(pick_from("\n\r"));
            end else if (kind < 64) begin
                add_str("/*");
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) text_q.push_back(pick_from("ab**//\n\r\"{"));
                if ($urandom_range(0, 3) == 0) text_q.push_back(CH_STAR);
                add_str("*/");
            end else if (kind < 76) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    text_q.push_back(pick_from(" :,0123456789truefalsenull\n\t"));
            end else if (kind < 86) begin
                text_q.push_back(any_byte());
            end else if (kind < 93) begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(pick_from("a1 \"{*/"));
            end else begin
                len = $urandom_range(2, 10);
                for (int i = 0; i < len; i++) text_q.push_back(pick_from("{["));
            end
        end
        // Break the tail of some texts
        case ($urandom_range(0, 19))
            0, 1: begin
                add_str("/*");
                len = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) text_q.push_back(pick_from("a*\n"));
            end
            2: text_q.push_back(CH_SLASH);
            3: add_str("/*x*");
            default: ;
        endcase
        if (text_q.size() == 0) text_q.push_back(any_byte());
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed_comments();
        // block comment with a kept newline, then a string with an escape
        text_q.delete();
        add_str("[/*a\n*/\"\\\"/\"]");
        send_text();
        // closing bracket at depth zero, text ends in a line comment
        text_q.delete();
        add_str("}x//c");
        send_text();
        // zero byte and all-ones byte are ordinary
        text_q.delete();
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(CH_SLASH);
        send_text();
        // end inside a block comment
        text_q.delete();
        add_str("/*z");
        send_text();
        // one-byte text
        text_q.delete();
        text_q.push_back(CH_SLASH);
        send_text();
    endtask

    task automatic test_directed_errors();
        write_max_nesting(8'd1);
        // nesting error, then later bytes pass unchanged
        text_q.delete();
        add_str("[[a/*b");
        send_text();
        // next text starts with a clean status
        text_q.delete();
        add_str("{}");
        send_text();
    endtask

    task automatic test_nesting_limits();
        write_max_nesting(8'd255);
        text_q.delete();
        for (int i = 0; i < 256; i++) text_q.push_back(CH_LBRACK);
        text_q.push_back(CH_RBRACK);
        send_text();
        // zero limit: every opening bracket fails
        write_max_nesting(8'd0);
        text_q.delete();
        add_str("[x/*");
        send_text();
        text_q.delete();
        add_str("a/*b");
        send_text();
    endtask

    task automatic test_backpressure();
        write_max_nesting(8'd32);
        tx_no_idle = 1'b1;
        rx_hold_reqs++;
        for (int k = 0; k < 6; k++) begin
            build_random_text();
            send_text();
        end
        tx_no_idle = 1'b0;
        wait_results();
    endtask

    task automatic test_sender_pause();
        text_q.delete();
        add_str("{\"k\":/* note */[1,2]// end\n}");
        send_text_paused(7);
        build_random_text();
        send_text_paused(text_q.size() / 2);
    endtask

    task automatic test_random_texts();
        int sent, phase, base;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            case (phase % 6)
                0: write_max_nesting(8'd255);
                1: write_max_nesting(8'd1);
                2: write_max_nesting(DEPTH_W'($urandom_range(2, 6)));
                3: write_max_nesting(8'd32);
                4: write_max_nesting(DEPTH_W'($urandom_range(1, 255)));
                default: write_max_nesting(DEPTH_W'($urandom_range(1, 12)));
            endcase
            tx_no_idle = (phase % 4 == 3);
            rx_no_idle = (phase % 4 == 3);
            base = sent;
            while (sent - base < PHASE_BYTES && sent < RANDOM_BYTES) begin
                build_random_text();
                if ($urandom_range(0, 14) == 0 && text_q.size() > 1)
                    send_text_paused($urandom_range(1, text_q.size() - 1));
                else
                    send_text();
                sent += text_q.size();
            end
            phase++;
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Long text that never closes its block comment: error one past the end.
    task automatic test_long_text();
        write_max_nesting(8'd32);
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_STAR, 1'b0);
        for (int i = 2; i < LONG_TEXT_LEN; i++)
            send_byte(pick_from("xy*\n"), i == LONG_TEXT_LEN - 1);
        n_texts++;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        wait_idle();
    endtask

    initial begin
        max_nest_model = DEF_MAX_NESTING;
        err_status     = STATUS_OK;
        err_pos        = '0;
        clear_text_state();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_comments();
        test_directed_errors();
        test_nesting_limits();
        test_backpressure();
        test_sender_pause();
        test_random_texts();
        test_long_text();
        wait_idle();

        if (pending_words.size() != 0)
            report_mismatch("words never returned", 32'(pending_words.size()), 0);
        $display("Covered %0d texts, %0d input bytes, %0d output words, %0d register writes,",
                 n_texts, n_bytes, n_results, n_cfg);
        $display("with comments, strings, nesting limits, stalls and a long unclosed comment.");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/jcs_pkg.sv
hdl/jcs_front.sv
hdl/jcs_queue.sv
hdl/jcs_back.sv
hdl/json_comment_stripper_unit.sv
hdl/jcs_checker.sv
sim/tb_top.sv
